>>> rtl/core/type1_charstring_decoder_core_macros.svh
// Assertion macros for the charstring decoder RTL.
// Included by bare file name; no other dependencies.
`ifndef TYPE1_CHARSTRING_DECODER_CORE_MACROS_SVH
`define TYPE1_CHARSTRING_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define T1CS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("t1cs assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define T1CS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("t1cs assertion failed");

`endif

>>> rtl/core/t1cs_pkg.sv
// Shared types and constants for the Type 1 charstring decoder.
// No dependencies; imported by every module of the block.
package t1cs_pkg;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_START_EEXEC = 2'd0,
        OP_START_CS    = 2'd1,
        OP_EEXEC_BYTE  = 2'd2,
        OP_CS_BYTE     = 2'd3
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_CMD    = 2'd1,
        KIND_NUM    = 2'd2,
        KIND_BADHEX = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_HEX_MODE   = 2'd0,
        REG_EEXEC_KEY  = 2'd1,
        REG_CS_KEY     = 2'd2,
        REG_LEAD_BYTES = 2'd3
    } reg_idx_t;

    // Configuration reset values
    localparam logic [15:0] EEXEC_KEY_RST = 16'd55665;
    localparam logic [15:0] CS_KEY_RST    = 16'd4330;
    localparam logic [2:0]  LEAD_RST      = 3'd4;

    // Cipher step constants
    localparam logic [15:0] CRYPT_MUL = 16'd52845;
    localparam logic [15:0] CRYPT_ADD = 16'd22719;

    // Charstring token encoding
    localparam logic [7:0]  TOK_CMD_LIMIT = 8'd32;
    localparam logic [7:0]  TOK_ESCAPE    = 8'd12;
    localparam logic [7:0]  TOK_SMALL_MAX = 8'd246;
    localparam logic [7:0]  TOK_POS_MAX   = 8'd250;
    localparam logic [7:0]  TOK_NEG_MAX   = 8'd254;
    localparam logic [7:0]  TOK_POS_BASE  = 8'd247;
    localparam logic [7:0]  TOK_NEG_BASE  = 8'd251;
    localparam logic [31:0] TOK_BIAS      = 32'd139;
    localparam logic [10:0] TOK_SHORT_OFS = 11'd108;
    localparam logic [8:0]  TOK_ESC_BASE  = 9'd32;

    // Hex front end result
    typedef struct packed {
        logic       ok;     // full byte available
        logic       bad;    // character is not hex or whitespace
        logic [7:0] data;
    } hex_res_t;

    // Cipher stage result
    typedef struct packed {
        logic       eexec_emit;   // plain eexec byte to deliver
        logic       token_step;   // charstring plaintext to tokenize
        logic [7:0] outer_plain;
        logic [7:0] inner_plain;
    } cipher_res_t;

    // Tokenizer result
    typedef struct packed {
        logic        emit;
        kind_t       kind;
        logic [31:0] value;
    } token_res_t;

endpackage

>>> rtl/core/t1cs_hex.sv
// Hex front end: turns raw or ASCII-hex input characters into bytes.
// Depends on t1cs_pkg.
module t1cs_hex
    import t1cs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       clear,
    input  logic       hex_mode,
    input  logic [7:0] raw_char,
    output hex_res_t   res
);

    logic       pending_reg;
    logic       pending_next;
    logic [3:0] high_reg;
    logic [3:0] high_next;
    logic       is_ws;
    logic       is_digit;
    logic [3:0] digit;

    // Whitespace: tab, newline, vertical tab, form feed, return, space
    assign is_ws = (raw_char == 8'd32) || ((raw_char >= 8'd9) && (raw_char <= 8'd13));

    // Digit decode
    always_comb
    begin
        is_digit = 1'b1;
        digit    = 4'd0;
        if ((raw_char >= 8'h30) && (raw_char <= 8'h39))
        begin
            digit = 4'(raw_char - 8'h30);
        end
        else if ((raw_char >= 8'h41) && (raw_char <= 8'h46))
        begin
            digit = 4'(raw_char - 8'h37);
        end
        else if ((raw_char >= 8'h61) && (raw_char <= 8'h66))
        begin
            digit = 4'(raw_char - 8'h57);
        end
        else
        begin
            is_digit = 1'b0;
        end
    end

    // Byte assembly and nibble holding
    always_comb
    begin
        res          = '0;
        pending_next = pending_reg;
        high_next    = high_reg;
        if (!hex_mode)
        begin
            res.ok   = 1'b1;
            res.data = raw_char;
        end
        else if (!is_ws)
        begin
            if (!is_digit)
            begin
                res.bad      = 1'b1;
                pending_next = 1'b0;
            end
            else if (pending_reg)
            begin
                res.ok       = 1'b1;
                res.data     = {high_reg, digit};
                pending_next = 1'b0;
            end
            else
            begin
                high_next    = digit;
                pending_next = 1'b1;
            end
        end
        if (clear)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            high_reg    <= 4'd0;
        end
        else if (step || clear)
        begin
            pending_reg <= pending_next;
            high_reg    <= high_next;
        end
    end

endmodule

>>> rtl/core/t1cs_cipher.sv
// Two-layer running cipher (outer eexec, inner charstring) with lead-byte drop.
// Depends on t1cs_pkg.
module t1cs_cipher
    import t1cs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_outer,
    input  logic        load_inner,
    input  logic [15:0] eexec_key,
    input  logic [15:0] charstring_key,
    input  logic [2:0]  lead_bytes,
    input  logic        step,
    input  logic        charstring,
    input  logic [7:0]  data,
    output cipher_res_t res
);

    logic [15:0] outer_reg;
    logic [15:0] inner_reg;
    logic [2:0]  outer_left_reg;
    logic [2:0]  inner_left_reg;
    logic        outer_live;
    logic        inner_live;
    logic        inner_step;

    // One cipher step: R' = (c + R) * MUL + ADD, mod 2^16
    function automatic logic [15:0] crypt_next(input logic [15:0] r, input logic [7:0] c);
        logic [15:0] sum;
        logic [31:0] prod;
        sum  = r + {8'h00, c};
        prod = {16'h0000, sum} * {16'h0000, CRYPT_MUL};
        return prod[15:0] + CRYPT_ADD;
    endfunction

    assign outer_live = (outer_left_reg == 3'd0);
    assign inner_live = (inner_left_reg == 3'd0);
    assign inner_step = step && outer_live && charstring;

    // Plaintext and routing
    always_comb
    begin
        res             = '0;
        res.outer_plain = data ^ outer_reg[15:8];
        res.inner_plain = res.outer_plain ^ inner_reg[15:8];
        res.eexec_emit  = step && outer_live && !charstring;
        res.token_step  = inner_step && inner_live;
    end

    // Outer layer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_reg      <= EEXEC_KEY_RST;
            outer_left_reg <= 3'd0;
        end
        else if (load_outer)
        begin
            outer_reg      <= eexec_key;
            outer_left_reg <= lead_bytes;
        end
        else if (step)
        begin
            outer_reg <= crypt_next(outer_reg, data);
            if (!outer_live)
            begin
                outer_left_reg <= outer_left_reg - 3'd1;
            end
        end
    end

    // Inner layer, fed by outer plaintext
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg      <= CS_KEY_RST;
            inner_left_reg <= 3'd0;
        end
        else if (load_inner)
        begin
            inner_reg      <= charstring_key;
            inner_left_reg <= lead_bytes;
        end
        else if (inner_step)
        begin
            inner_reg <= crypt_next(inner_reg, res.outer_plain);
            if (!inner_live)
            begin
                inner_left_reg <= inner_left_reg - 3'd1;
            end
        end
    end

endmodule

>>> rtl/core/t1cs_token.sv
// Charstring tokenizer: commands, escaped commands, 1-, 2- and 5-byte numbers.
// Depends on t1cs_pkg.
module t1cs_token
    import t1cs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       step,
    input  logic [7:0] c,
    output token_res_t res
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_POS  = 3'd2,
        PH_NEG  = 3'd3,
        PH_LONG = 3'd4
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [1:0]  left_reg;
    logic [1:0]  left_next;
    logic [1:0]  shb_reg;
    logic [1:0]  shb_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        emit;
    kind_t       kind;
    logic [31:0] value;
    logic [10:0] short_mag;
    logic [8:0]  esc_cmd;
    logic [7:0]  pos_off;
    logic [7:0]  neg_off;

    assign short_mag = {1'b0, shb_reg, c} + TOK_SHORT_OFS;
    assign esc_cmd   = {1'b0, c} + TOK_ESC_BASE;
    assign pos_off   = c - TOK_POS_BASE;
    assign neg_off   = c - TOK_NEG_BASE;

    // Next state and token output
    always_comb
    begin
        phase_next = PH_IDLE;
        left_next  = left_reg;
        shb_next   = shb_reg;
        acc_next   = acc_reg;
        emit       = 1'b0;
        kind       = KIND_NUM;
        value      = 32'd0;
        case (phase_reg)
            PH_ESC:
            begin
                emit  = 1'b1;
                kind  = KIND_CMD;
                value = {23'd0, esc_cmd};
            end
            PH_POS:
            begin
                emit  = 1'b1;
                value = {21'd0, short_mag};
            end
            PH_NEG:
            begin
                emit  = 1'b1;
                value = 32'd0 - {21'd0, short_mag};
            end
            PH_LONG:
            begin
                acc_next = {acc_reg[23:0], c};
                if (left_reg == 2'd0)
                begin
                    emit  = 1'b1;
                    value = acc_next;
                end
                else
                begin
                    phase_next = PH_LONG;
                    left_next  = left_reg - 2'd1;
                end
            end
            default:
            begin
                if (c < TOK_CMD_LIMIT)
                begin
                    if (c == TOK_ESCAPE)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        emit  = 1'b1;
                        kind  = KIND_CMD;
                        value = {24'd0, c};
                    end
                end
                else if (c <= TOK_SMALL_MAX)
                begin
                    emit  = 1'b1;
                    value = {24'd0, c} - TOK_BIAS;
                end
                else if (c <= TOK_POS_MAX)
                begin
                    phase_next = PH_POS;
                    shb_next   = pos_off[1:0];
                end
                else if (c <= TOK_NEG_MAX)
                begin
                    phase_next = PH_NEG;
                    shb_next   = neg_off[1:0];
                end
                else
                begin
                    phase_next = PH_LONG;
                    left_next  = 2'd3;
                    acc_next   = 32'd0;
                end
            end
        endcase
    end

    always_comb
    begin
        res.emit  = step && emit;
        res.kind  = kind;
        res.value = value;
    end

    // Tokenizer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= 2'd0;
            shb_reg   <= 2'd0;
            acc_reg   <= 32'd0;
        end
        else if (clear)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= 2'd0;
            shb_reg   <= 2'd0;
            acc_reg   <= 32'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            shb_reg   <= shb_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

>>> rtl/core/type1_charstring_decoder_core.sv
// Type 1 charstring decoder top level: config registers, request and result stages.
// Depends on t1cs_pkg, t1cs_hex, t1cs_cipher, t1cs_token and the assertion macros.
//
// Takes one request per clock and sustains that rate indefinitely while the result
// side keeps up. A request waits in the input register until the result register is
// free or being emptied; as it leaves, hex assembly, both cipher layers and the
// tokenizer update their state (the loop that sets the rate is the 16-bit constant
// multiply-add of each cipher register), and its result, if any, is shown the next
// cycle from the result register. A request that yields no result still passes the
// same stages. Registers sit at byte addresses 0, 4, 8 and 12 of the APB port.
`include "type1_charstring_decoder_core_macros.svh"

module type1_charstring_decoder_core
    import t1cs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request channel
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         operation,
    input  logic [7:0]         raw_char,
    // result channel
    output logic               result_valid,
    input  logic               result_ready,
    output logic [1:0]         kind,
    output logic signed [31:0] value
);

    logic        hex_mode_reg;
    logic [15:0] eexec_key_reg;
    logic [15:0] cs_key_reg;
    logic [2:0]  lead_reg;
    reg_idx_t    reg_idx;
    logic        cfg_write;

    logic        in_valid_reg;
    op_t         op_reg;
    logic [7:0]  rc_reg;
    logic        fire;
    logic        byte_op;
    logic        charstring;

    hex_res_t    hex_res;
    cipher_res_t ciph_res;
    token_res_t  tok_res;

    logic        res_emit;
    kind_t       res_kind;
    logic [31:0] res_value;
    logic        result_valid_reg;
    kind_t       kind_reg;
    logic [31:0] value_reg;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_mode_reg  <= 1'b0;
            eexec_key_reg <= EEXEC_KEY_RST;
            cs_key_reg    <= CS_KEY_RST;
            lead_reg      <= LEAD_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_HEX_MODE:   hex_mode_reg  <= pwdata[0];
                REG_EEXEC_KEY:  eexec_key_reg <= pwdata[15:0];
                REG_CS_KEY:     cs_key_reg    <= pwdata[15:0];
                REG_LEAD_BYTES: lead_reg      <= pwdata[2:0];
                default:        lead_reg      <= lead_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HEX_MODE:   prdata = {31'd0, hex_mode_reg};
            REG_EEXEC_KEY:  prdata = {16'd0, eexec_key_reg};
            REG_CS_KEY:     prdata = {16'd0, cs_key_reg};
            REG_LEAD_BYTES: prdata = {29'd0, lead_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Request register
    assign fire       = in_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || fire;
    assign byte_op    = (op_reg == OP_EEXEC_BYTE) || (op_reg == OP_CS_BYTE);
    assign charstring = (op_reg == OP_CS_BYTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            op_reg <= op_t'(operation);
            rc_reg <= raw_char;
        end
    end

    // Processing units
    t1cs_hex u_hex (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (fire && byte_op),
        .clear    (fire && !byte_op),
        .hex_mode (hex_mode_reg),
        .raw_char (rc_reg),
        .res      (hex_res)
    );

    t1cs_cipher u_cipher (
        .clk            (clk),
        .rst_n          (rst_n),
        .load_outer     (fire && (op_reg == OP_START_EEXEC)),
        .load_inner     (fire && (op_reg == OP_START_CS)),
        .eexec_key      (eexec_key_reg),
        .charstring_key (cs_key_reg),
        .lead_bytes     (lead_reg),
        .step           (fire && byte_op && hex_res.ok),
        .charstring     (charstring),
        .data           (hex_res.data),
        .res            (ciph_res)
    );

    t1cs_token u_token (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (fire && !byte_op),
        .step  (ciph_res.token_step),
        .c     (ciph_res.inner_plain),
        .res   (tok_res)
    );

    // Result select
    always_comb
    begin
        res_emit  = 1'b0;
        res_kind  = KIND_BYTE;
        res_value = 32'd0;
        if (fire && byte_op && hex_res.bad)
        begin
            res_emit  = 1'b1;
            res_kind  = KIND_BADHEX;
            res_value = {24'd0, rc_reg};
        end
        else if (ciph_res.eexec_emit)
        begin
            res_emit  = 1'b1;
            res_value = {24'd0, ciph_res.outer_plain};
        end
        else if (tok_res.emit)
        begin
            res_emit  = 1'b1;
            res_kind  = tok_res.kind;
            res_value = tok_res.value;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            result_valid_reg <= res_emit;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_emit)
        begin
            kind_reg  <= res_kind;
            value_reg <= res_value;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign value        = value_reg;

    // Checks
    `T1CS_ASSERT_NOW(a_badhex_in_hex_mode, clk, rst_n, result_valid_reg && (kind_reg == KIND_BADHEX), hex_mode_reg)
    `T1CS_ASSERT_NOW(a_byte_range, clk, rst_n, result_valid_reg && ((kind_reg == KIND_BYTE) || (kind_reg == KIND_BADHEX)), value_reg[31:8] == 24'd0)
    `T1CS_ASSERT_NOW(a_cmd_range, clk, rst_n, result_valid_reg && (kind_reg == KIND_CMD), value_reg[31:9] == 23'd0)
    `T1CS_ASSERT_NEXT(a_result_has_request, clk, rst_n, !result_valid_reg && !in_valid_reg, !result_valid_reg)

endmodule

>>> bench/type1_charstring_decoder_core_tb.sv
// Self-checking bench for type1_charstring_decoder_core: directed table, back-pressure run, then random phases.
// Depends on t1cs_pkg; a behavioral decryptor/tokenizer predicts every result the directed table does not give.
module type1_charstring_decoder_core_tb;
    import t1cs_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned PHASE_ITEMS  = 135;
    localparam int unsigned RAND_PHASES  = 7;

    localparam logic [7:0] ASCII_TAB   = 8'd9;
    localparam logic [7:0] ASCII_CR    = 8'd13;
    localparam logic [7:0] ASCII_SPACE = 8'd32;
    localparam logic [7:0] LONG_PREFIX = 8'd255;

    typedef enum logic [2:0] {
        TP_IDLE, TP_ESC, TP_POS, TP_NEG, TP_LONG
    } token_phase_t;

    typedef enum logic [1:0] {
        ROW_REQ,    // raw request character
        ROW_PLAIN,  // character is the wanted plaintext, encrypted on the fly
        ROW_CFG     // register write
    } row_kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
    } token_t;

    typedef struct {
        row_kind_t   what;
        op_t         op;
        reg_idx_t    idx;
        logic [15:0] arg;
        bit          typed;
        token_t      tok;
    } dir_row_t;

    localparam token_t NO_TOKEN = '{kind: KIND_BYTE, value: 32'd0};

    // DUT signals
    logic               clk;
    logic               rst_n        = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [3:0]         paddr        = 4'd0;
    logic [31:0]        pwdata       = 32'd0;
    logic [31:0]        prdata;
    logic               pready;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    logic [1:0]         operation    = 2'd0;
    logic [7:0]         raw_char     = 8'd0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [1:0]         kind;
    logic signed [31:0] value;

    type1_charstring_decoder_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .raw_char     (raw_char),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .value        (value)
    );

    // Predictor state: configuration copy and decoder state
    logic         cfg_hex;
    logic [15:0]  cfg_eexec_key;
    logic [15:0]  cfg_cs_key;
    logic [2:0]   cfg_lead;
    logic [15:0]  outer_r;
    logic [15:0]  inner_r;
    logic [2:0]   outer_skip;
    logic [2:0]   inner_skip;
    logic         nib_held;
    logic [3:0]   nib_hi;
    token_phase_t token_state;
    logic [1:0]   long_left;
    logic [1:0]   short_hi;
    logic [31:0]  long_acc;

    token_t      pending_tokens[$];
    dir_row_t    directed_rows[$];
    int unsigned error_count   = 0;
    int unsigned requests_sent = 0;
    int unsigned cycle_count   = 0;
    int unsigned hold_off_len  = 0;
    bit          idle_on       = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] next_key(logic [15:0] r, logic [7:0] c);
        logic [15:0] s;
        s = r + {8'h00, c};
        return s * CRYPT_MUL + CRYPT_ADD;
    endfunction

    function automatic bit is_blank(logic [7:0] ch);
        return ch == ASCII_SPACE || (ch >= ASCII_TAB && ch <= ASCII_CR);
    endfunction

    // {valid, digit}
    function automatic logic [4:0] hex_nibble(logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return {1'b1, 4'(ch - "0")};
        if (ch >= "A" && ch <= "F") return {1'b1, 4'(ch - "A" + 8'd10)};
        if (ch >= "a" && ch <= "f") return {1'b1, 4'(ch - "a" + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] d);
        if (d < 4'd10) return "0" + 8'(d);
        if ($urandom_range(0, 1) == 0) return "A" + 8'(d - 4'd10);
        return "a" + 8'(d - 4'd10);
    endfunction

    function automatic void clear_tokenizer();
        token_state = TP_IDLE;
        long_left   = 2'd0;
        short_hi    = 2'd0;
        long_acc    = 32'd0;
    endfunction

    function automatic void init_model();
        cfg_hex       = 1'b0;
        cfg_eexec_key = EEXEC_KEY_RST;
        cfg_cs_key    = CS_KEY_RST;
        cfg_lead      = LEAD_RST;
        outer_r       = EEXEC_KEY_RST;
        inner_r       = CS_KEY_RST;
        outer_skip    = 3'd0;
        inner_skip    = 3'd0;
        nib_held      = 1'b0;
        nib_hi        = 4'd0;
        clear_tokenizer();
    endfunction

    // Charstring plaintext byte into the tokenizer
    function automatic void tokenize(input logic [7:0] q, output bit produced,
                                     output token_t tok);
        logic [31:0] mag;
        produced = 1'b0;
        tok      = NO_TOKEN;
        mag      = 32'({short_hi, q}) + 32'(TOK_SHORT_OFS);
        case (token_state)
            TP_ESC:
            begin
                token_state = TP_IDLE;
                produced    = 1'b1;
                tok         = '{KIND_CMD, 32'(TOK_ESC_BASE) + 32'(q)};
            end
            TP_POS:
            begin
                token_state = TP_IDLE;
                produced    = 1'b1;
                tok         = '{KIND_NUM, mag};
            end
            TP_NEG:
            begin
                token_state = TP_IDLE;
                produced    = 1'b1;
                tok         = '{KIND_NUM, 32'd0 - mag};
            end
            TP_LONG:
            begin
                long_acc = {long_acc[23:0], q};
                if (long_left == 2'd0)
                begin
                    token_state = TP_IDLE;
                    produced    = 1'b1;
                    tok         = '{KIND_NUM, long_acc};
                end
                else
                begin
                    long_left = long_left - 2'd1;
                end
            end
            default:
            begin
                token_state = TP_IDLE;
                if (q < TOK_CMD_LIMIT)
                begin
                    if (q == TOK_ESCAPE)
                    begin
                        token_state = TP_ESC;
                    end
                    else
                    begin
                        produced = 1'b1;
                        tok      = '{KIND_CMD, 32'(q)};
                    end
                end
                else if (q <= TOK_SMALL_MAX)
                begin
                    produced = 1'b1;
                    tok      = '{KIND_NUM, 32'(q) - TOK_BIAS};
                end
                else if (q <= TOK_POS_MAX)
                begin
                    short_hi    = 2'(q - TOK_POS_BASE);
                    token_state = TP_POS;
                end
                else if (q <= TOK_NEG_MAX)
                begin
                    short_hi    = 2'(q - TOK_NEG_BASE);
                    token_state = TP_NEG;
                end
                else
                begin
                    token_state = TP_LONG;
                    long_left   = 2'd3;
                    long_acc    = 32'd0;
                end
            end
        endcase
    endfunction

    // One accepted request through hex front end, both cipher layers and tokenizer
    function automatic void decode_request(input op_t op, input logic [7:0] rc,
                                           output bit produced, output token_t tok);
        logic [7:0] cbyte;
        logic [7:0] p;
        logic [7:0] q;
        logic [4:0] nib;
        bit         have_byte;
        produced  = 1'b0;
        tok       = NO_TOKEN;
        have_byte = 1'b0;
        cbyte     = 8'd0;
        case (op)
            OP_START_EEXEC:
            begin
                outer_r    = cfg_eexec_key;
                outer_skip = cfg_lead;
                nib_held   = 1'b0;
                clear_tokenizer();
            end
            OP_START_CS:
            begin
                inner_r    = cfg_cs_key;
                inner_skip = cfg_lead;
                nib_held   = 1'b0;
                clear_tokenizer();
            end
            default:
            begin
                if (!cfg_hex)
                begin
                    cbyte     = rc;
                    have_byte = 1'b1;
                end
                else if (!is_blank(rc))
                begin
                    nib = hex_nibble(rc);
                    if (!nib[4])
                    begin
                        // bad digit drops any held nibble, nothing else moves
                        nib_held = 1'b0;
                        produced = 1'b1;
                        tok      = '{KIND_BADHEX, {24'd0, rc}};
                    end
                    else if (!nib_held)
                    begin
                        nib_hi   = nib[3:0];
                        nib_held = 1'b1;
                    end
                    else
                    begin
                        nib_held  = 1'b0;
                        cbyte     = {nib_hi, nib[3:0]};
                        have_byte = 1'b1;
                    end
                end
                if (have_byte)
                begin
                    p       = cbyte ^ outer_r[15:8];
                    outer_r = next_key(outer_r, cbyte);
                    if (outer_skip != 3'd0)
                    begin
                        outer_skip = outer_skip - 3'd1;
                    end
                    else if (op == OP_EEXEC_BYTE)
                    begin
                        produced = 1'b1;
                        tok      = '{KIND_BYTE, {24'd0, p}};
                    end
                    else
                    begin
                        q       = p ^ inner_r[15:8];
                        inner_r = next_key(inner_r, p);
                        if (inner_skip != 3'd0)
                            inner_skip = inner_skip - 3'd1;
                        else
                            tokenize(q, produced, tok);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %08h want %08h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic check_result(logic [1:0] got_kind, logic [31:0] got_value);
        token_t want;
        if (pending_tokens.size() == 0)
        begin
            report_mismatch("result with nothing pending", got_value, 32'd0);
        end
        else
        begin
            want = pending_tokens.pop_front();
            if (got_kind !== want.kind)
                report_mismatch("kind", {30'd0, got_kind}, {30'd0, want.kind});
            if (got_value !== want.value)
                report_mismatch("value", got_value, want.value);
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_request(op_t op, logic [7:0] rc, bit typed, token_t typed_tok);
        int unsigned gap;
        bit          produced;
        token_t      tok;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        raw_char   <= rc;
        do @(posedge clk); while (!item_ready);
        decode_request(op, rc, produced, tok);
        if (typed)
            pending_tokens.push_back(typed_tok);
        else if (produced)
            pending_tokens.push_back(tok);
        if (!(cfg_hex && op != OP_START_EEXEC && op != OP_START_CS && is_blank(rc)))
            requests_sent++;
    endtask

    // Occasional hex whitespace between digits
    task automatic maybe_blank(op_t op);
        int unsigned w;
        if ($urandom_range(0, 7) == 0)
        begin
            w = $urandom_range(0, 5);
            send_request(op, (w == 5) ? ASCII_SPACE : ASCII_TAB + 8'(w), 1'b0, NO_TOKEN);
        end
    endtask

    // Encrypt a wanted plaintext against the current cipher state and send it
    task automatic send_plain(op_t op, logic [7:0] plain, bit typed, token_t typed_tok);
        logic [7:0] c;
        if (cfg_hex && nib_held)
            send_request(op, hex_char(4'($urandom_range(0, 15))), 1'b0, NO_TOKEN);
        c = plain ^ outer_r[15:8];
        if (op == OP_CS_BYTE)
            c = c ^ inner_r[15:8];
        if (!cfg_hex)
        begin
            send_request(op, c, typed, typed_tok);
        end
        else
        begin
            maybe_blank(op);
            send_request(op, hex_char(c[7:4]), 1'b0, NO_TOKEN);
            maybe_blank(op);
            send_request(op, hex_char(c[3:0]), typed, typed_tok);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup and access phases, then bus idle before the next transfer
    task automatic apb_write(reg_idx_t idx, logic [15:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, data};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_HEX_MODE:   cfg_hex       = data[0];
            REG_EEXEC_KEY:  cfg_eexec_key = data;
            REG_CS_KEY:     cfg_cs_key    = data;
            REG_LEAD_BYTES: cfg_lead      = data[2:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // One well-formed charstring token with random content
    task automatic send_random_token();
        int unsigned pick;
        int unsigned sel;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            send_plain(OP_CS_BYTE, 8'($urandom_range(0, 31)), 1'b0, NO_TOKEN);
        end
        else if (pick < 25)
        begin
            send_plain(OP_CS_BYTE, TOK_ESCAPE, 1'b0, NO_TOKEN);
            send_plain(OP_CS_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_TOKEN);
        end
        else if (pick < 55)
        begin
            send_plain(OP_CS_BYTE, 8'($urandom_range(TOK_CMD_LIMIT, TOK_SMALL_MAX)),
                       1'b0, NO_TOKEN);
        end
        else if (pick < 70)
        begin
            send_plain(OP_CS_BYTE, 8'($urandom_range(TOK_POS_BASE, TOK_POS_MAX)),
                       1'b0, NO_TOKEN);
            send_plain(OP_CS_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_TOKEN);
        end
        else if (pick < 85)
        begin
            send_plain(OP_CS_BYTE, 8'($urandom_range(TOK_NEG_BASE, TOK_NEG_MAX)),
                       1'b0, NO_TOKEN);
            send_plain(OP_CS_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_TOKEN);
        end
        else
        begin
            send_plain(OP_CS_BYTE, LONG_PREFIX, 1'b0, NO_TOKEN);
            repeat (4)
            begin
                // lean toward all-zero / all-one bytes for the 32-bit extremes
                sel = $urandom_range(0, 3);
                b   = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                send_plain(OP_CS_BYTE, b, 1'b0, NO_TOKEN);
            end
        end
    endtask

    task automatic send_random_unit();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // noise: any op, any character
            send_request(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'b0, NO_TOKEN);
        end
        else if (pick < 14)
        begin
            // charstring restart followed by its lead bytes
            send_request(OP_START_CS, 8'($urandom_range(0, 255)), 1'b0, NO_TOKEN);
            repeat (cfg_lead)
                send_plain(OP_CS_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_TOKEN);
        end
        else if (pick < 16)
        begin
            send_request(OP_START_EEXEC, 8'($urandom_range(0, 255)), 1'b0, NO_TOKEN);
        end
        else if (pick < 18)
        begin
            drain_results();
        end
        else if (pick < 35)
        begin
            send_plain(OP_EEXEC_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_TOKEN);
        end
        else
        begin
            send_random_token();
        end
    endtask

    function automatic void add_row(row_kind_t what, op_t op, reg_idx_t idx,
                                    logic [15:0] arg, bit typed, kind_t k,
                                    logic [31:0] v);
        directed_rows.push_back('{what, op, idx, arg, typed, '{k, v}});
    endfunction

    function automatic void build_directed_rows();
        // reset config: raw mode, four lead bytes, outer layer not in lead
        add_row(ROW_REQ,   OP_EEXEC_BYTE,  REG_HEX_MODE, 16'hD9, 1, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_START_CS,    REG_HEX_MODE, 16'h00, 0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_CS_BYTE,     REG_HEX_MODE, 16'h00, 0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_CS_BYTE,     REG_HEX_MODE, 16'hFF, 0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_CS_BYTE,     REG_HEX_MODE, 16'h5A, 0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_CS_BYTE,     REG_HEX_MODE, 16'hA5, 0, KIND_BYTE, 32'd0);
        // token forms
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'd0,   1, KIND_CMD, 32'd0);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'd12,  0, KIND_BYTE, 32'd0);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'd255, 1, KIND_CMD, 32'd287);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'd32,  1, KIND_NUM, -32'sd107);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'd246, 1, KIND_NUM, 32'd107);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'd250, 0, KIND_BYTE, 32'd0);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'd255, 1, KIND_NUM, 32'd1131);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'd254, 0, KIND_BYTE, 32'd0);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'd0,   1, KIND_NUM, -32'sd876);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'd255, 0, KIND_BYTE, 32'd0);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'h80,  0, KIND_BYTE, 32'd0);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'h00,  0, KIND_BYTE, 32'd0);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'h00,  0, KIND_BYTE, 32'd0);
        add_row(ROW_PLAIN, OP_CS_BYTE,     REG_HEX_MODE, 16'h00, 1, KIND_NUM, 32'h80000000);
        // charstring byte swallowed by the outer lead
        add_row(ROW_REQ,   OP_START_EEXEC, REG_HEX_MODE, 16'hFF, 0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_CS_BYTE,     REG_HEX_MODE, 16'h3C, 0, KIND_BYTE, 32'd0);
        // hex front end
        add_row(ROW_CFG,   OP_START_EEXEC, REG_LEAD_BYTES, 16'd0, 0, KIND_BYTE, 32'd0);
        add_row(ROW_CFG,   OP_START_EEXEC, REG_HEX_MODE,   16'd1, 0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_START_EEXEC, REG_HEX_MODE, 16'h00, 0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_EEXEC_BYTE,  REG_HEX_MODE, 16'h20, 0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_EEXEC_BYTE,  REG_HEX_MODE, 16'hFF, 1, KIND_BADHEX, 32'hFF);
        add_row(ROW_REQ,   OP_CS_BYTE,     REG_HEX_MODE, 16'h00, 1, KIND_BADHEX, 32'h00);
        add_row(ROW_REQ,   OP_EEXEC_BYTE,  REG_HEX_MODE, 16'("5"), 0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_EEXEC_BYTE,  REG_HEX_MODE, 16'("z"), 1, KIND_BADHEX, 32'("z"));
        // held nibble survives a trip through raw mode
        add_row(ROW_REQ,   OP_EEXEC_BYTE,  REG_HEX_MODE, 16'("7"), 0, KIND_BYTE, 32'd0);
        add_row(ROW_CFG,   OP_START_EEXEC, REG_HEX_MODE, 16'd0,   0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_EEXEC_BYTE,  REG_HEX_MODE, 16'h41,  0, KIND_BYTE, 32'd0);
        add_row(ROW_CFG,   OP_START_EEXEC, REG_HEX_MODE, 16'd1,   0, KIND_BYTE, 32'd0);
        add_row(ROW_REQ,   OP_EEXEC_BYTE,  REG_HEX_MODE, 16'("c"), 0, KIND_BYTE, 32'd0);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_len > 0)
            begin
                stall        = hold_off_len;
                hold_off_len = 0;
            end
            else
            begin
                stall = idle_on ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            check_result(kind, value);
        end
    end

    // Timeout
    initial
    begin : watchdog
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned goal;
        init_model();
        build_directed_rows();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            case (directed_rows[i].what)
                ROW_CFG:
                begin
                    drain_results();
                    apb_write(directed_rows[i].idx, directed_rows[i].arg);
                end
                ROW_PLAIN: send_plain(directed_rows[i].op, directed_rows[i].arg[7:0],
                                      directed_rows[i].typed, directed_rows[i].tok);
                default:   send_request(directed_rows[i].op, directed_rows[i].arg[7:0],
                                        directed_rows[i].typed, directed_rows[i].tok);
            endcase
        end

        // back-pressure: receiver holds off while requests keep coming
        drain_results();
        apb_write(REG_HEX_MODE, 16'd0);
        apb_write(REG_LEAD_BYTES, 16'd0);
        idle_on = 1'b0;
        send_request(OP_START_EEXEC, 8'h00, 1'b0, NO_TOKEN);
        hold_off_len = 300;
        repeat (60) send_plain(OP_EEXEC_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_TOKEN);

        // random phases under different settings
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    apb_write(REG_HEX_MODE, 16'd0);
                    apb_write(REG_EEXEC_KEY, 16'h0000);
                    apb_write(REG_CS_KEY, 16'h0000);
                    apb_write(REG_LEAD_BYTES, 16'd0);
                end
                1:
                begin
                    apb_write(REG_HEX_MODE, 16'd1);
                    apb_write(REG_EEXEC_KEY, 16'hFFFF);
                    apb_write(REG_CS_KEY, 16'hFFFF);
                    apb_write(REG_LEAD_BYTES, 16'd7);
                end
                2:
                begin
                    apb_write(REG_HEX_MODE, 16'd0);
                    apb_write(REG_EEXEC_KEY, EEXEC_KEY_RST);
                    apb_write(REG_CS_KEY, CS_KEY_RST);
                    apb_write(REG_LEAD_BYTES, 16'(LEAD_RST));
                end
                default:
                begin
                    apb_write(REG_HEX_MODE, 16'(phase % 2));
                    apb_write(REG_EEXEC_KEY, 16'($urandom_range(0, 65535)));
                    apb_write(REG_CS_KEY, 16'($urandom_range(0, 65535)));
                    apb_write(REG_LEAD_BYTES, 16'($urandom_range(0, 7)));
                end
            endcase
            // some phases run with no gaps on either side
            idle_on = (phase != 2 && phase != 5);
            send_request(OP_START_EEXEC, 8'($urandom_range(0, 255)), 1'b0, NO_TOKEN);
            goal = requests_sent + PHASE_ITEMS;
            while (requests_sent < goal) send_random_unit();
        end

        drain_results();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
